[design/bic_pkg.sv]
// package: constants, types and arithmetic helpers of the barometer compensation pipeline
`default_nettype none
package bic_pkg;

   localparam int NumCoef  = 6;
   localparam int CsrIdxW  = 3;
   localparam int DivBits  = 64;
   localparam int FrontStg = 13;
   localparam int BackStg  = 6;
   localparam int NumStg   = FrontStg + DivBits + BackStg;
   localparam int TempStg  = 3;
   localparam int TempDly  = NumStg - 1 - TempStg;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_T1_T2 = 3'd0,
      CSR_T3_P1 = 3'd1,
      CSR_P2_P3 = 3'd2,
      CSR_P4_P5 = 3'd3,
      CSR_P6_P7 = 3'd4,
      CSR_P8_P9 = 3'd5
   } csr_idx_type;

   // partial products of a 64-bit word times a 17-bit signed factor
   typedef struct packed {
      logic [49:0] lo;
      logic [31:0] hi;
   } mpp_type;

   // partial products of a 64-bit square, low 64 bits only
   typedef struct packed {
      logic [63:0] ll;
      logic [31:0] lh;
   } sqpp_type;

   function automatic logic [31:0] asr32(logic [31:0] x, int unsigned n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic logic [63:0] asr64(logic [63:0] x, int unsigned n);
      return 64'($signed(x) >>> n);
   endfunction

   function automatic mpp_type mul_pp(logic [63:0] a, logic signed [16:0] c);
      logic signed [49:0] lo;
      logic signed [49:0] hi;
      mpp_type r;
      lo = $signed({1'b0, a[31:0]}) * c;
      hi = $signed({1'b0, a[63:32]}) * c;
      r.lo = lo;
      r.hi = hi[31:0];
      return r;
   endfunction

   function automatic logic [63:0] mul_sum(mpp_type m);
      return {{14{m.lo[49]}}, m.lo} + {m.hi, 32'b0};
   endfunction

   function automatic sqpp_type sq_pp(logic [63:0] a);
      sqpp_type r;
      logic [63:0] lh;
      r.ll = a[31:0] * a[31:0];
      lh = a[31:0] * a[63:32];
      r.lh = lh[31:0];
      return r;
   endfunction

   function automatic logic [63:0] sq_sum(sqpp_type m);
      return m.ll + {m.lh[30:0], 33'b0};
   endfunction

endpackage
`default_nettype wire

[design/barometer_integer_compensation.sv]
// Barometer reading compensation: pipelined temperature and pressure correction.
//
// Requests carry one raw 20-bit pressure and one raw 20-bit temperature reading.
// Each request gives one response: temperature in 0.01 degC, pressure as
// unsigned Q24.8 pascal and a flag set when the pressure divisor is zero
// (pressure then reads 0).
// Six 32-bit calibration registers are written over the csr channel, which is
// always ready; write them only while no request is in flight.
// Throughput: one request per cycle while rsp_stall does not hold a response.
// A request passes 13 stages of multiply and add steps, 64 stages of the
// signed 64-bit divider (one quotient bit per stage) and 6 stages of final
// correction, then the output register.
// Reset clears the calibration registers and all valid bits.
// When the output register holds a response and rsp_stall is high, the whole
// pipeline freezes and req_stall is raised; nothing is lost or repeated.
`default_nettype none
module barometer_integer_compensation
   import bic_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [19:0]         req_raw_pressure,
   input  wire logic [19:0]         req_raw_temperature,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [31:0]       rsp_temperature_centi,
   output logic [31:0]              rsp_pressure_q24_8,
   output logic                     rsp_divide_by_zero,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [31:0]         csr_wdata
);

   logic [31:0] coef_ff [NumCoef];
   logic        en;
   logic        v_ff [NumStg];
   logic        rsp_valid_ff;

   logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;

   assign t1 = coef_ff[CSR_T1_T2][15:0];
   assign t2 = coef_ff[CSR_T1_T2][31:16];
   assign t3 = coef_ff[CSR_T3_P1][15:0];
   assign p1 = coef_ff[CSR_T3_P1][31:16];
   assign p2 = coef_ff[CSR_P2_P3][15:0];
   assign p3 = coef_ff[CSR_P2_P3][31:16];
   assign p4 = coef_ff[CSR_P4_P5][15:0];
   assign p5 = coef_ff[CSR_P4_P5][31:16];
   assign p6 = coef_ff[CSR_P6_P7][15:0];
   assign p7 = coef_ff[CSR_P6_P7][31:16];
   assign p8 = coef_ff[CSR_P8_P9][15:0];
   assign p9 = coef_ff[CSR_P8_P9][31:16];

   // front stage registers
   logic [31:0] s1_a_ff, s1_d_ff;
   logic [31:0] s2_v1_ff, s2_dd_ff;
   logic [31:0] s3_v1_ff, s3_v2_ff;
   logic [31:0] s4_temp_ff;
   logic [63:0] s4_x1_ff;
   sqpp_type    s5_sq_ff;
   mpp_type     s5_x1p5_ff, s5_x1p2_ff;
   logic [63:0] s6_sq_ff, s6_x1p5_ff, s6_x1p2_ff;
   mpp_type     s7_sqp6_ff, s7_sqp3_ff;
   logic [63:0] s7_x1p5_ff, s7_x1p2_ff;
   logic [63:0] s8_sqp6_ff, s8_sqp3_ff, s8_x1p5_ff, s8_x1p2_ff;
   logic [63:0] s9_x2_ff, s9_e_ff;
   mpp_type     s10_ep1_ff;
   logic [63:0] s10_n0_ff;
   logic [63:0] s11_c_ff;
   mpp_type     s11_n_ff;
   logic [63:0] s12_c_ff, s12_n_ff;
   logic [63:0] s13_ma_ff, s13_mb_ff;
   logic        s13_neg_ff, s13_dz_ff;

   // the raw pressure reading rides along until the step that needs it
   logic [19:0] adc_p_dly_ff [9];

   // divider stages
   logic [127:0] div_rq_ff [DivBits];
   logic [63:0]  div_mb_ff [DivBits];
   logic         div_neg_ff [DivBits];
   logic         div_dz_ff [DivBits];
   logic [127:0] div_src [DivBits];
   logic [63:0]  div_msrc [DivBits];
   logic [127:0] div_rq_in [DivBits];

   // back stage registers
   logic [63:0] b1_p_ff;
   logic [63:0] b2_p_ff;
   sqpp_type    b2_ss_ff;
   mpp_type     b2_p8_ff;
   logic [63:0] b3_p_ff, b3_s2_ff, b3_p8_ff;
   logic [63:0] b4_p_ff, b4_y2_ff;
   mpp_type     b4_s2p9_ff;
   logic [63:0] b5_p_ff, b5_y1_ff, b5_y2_ff;
   logic [63:0] b6_t_ff;
   logic        b_dz_ff [BackStg];

   logic [31:0] temp_dly_ff [TempDly];

   logic [31:0] out_temp_ff, out_pres_ff;
   logic        out_dz_ff;

   // combinational next values
   logic [31:0] s1_a_in, s1_d_in, s2_v1_in, s2_dd_in, s3_v2_in, s4_tfine_in, s4_t5_in;
   logic [63:0] s9_x2_in, s9_e_in, s10_pn_in, s10_n0_in, s12_n_in;
   logic [63:0] b1_p_in, b2_s_in, b6_t_in;
   logic [31:0] out_pres_in;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumCoef; i++) coef_ff[i] <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_T1_T2: coef_ff[CSR_T1_T2] <= csr_wdata;
            CSR_T3_P1: coef_ff[CSR_T3_P1] <= csr_wdata;
            CSR_P2_P3: coef_ff[CSR_P2_P3] <= csr_wdata;
            CSR_P4_P5: coef_ff[CSR_P4_P5] <= csr_wdata;
            CSR_P6_P7: coef_ff[CSR_P6_P7] <= csr_wdata;
            CSR_P8_P9: coef_ff[CSR_P8_P9] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_a_in     = 32'(req_raw_temperature[19:3]) - 32'({t1, 1'b0});
      s1_d_in     = 32'(req_raw_temperature[19:4]) - 32'(t1);
      s2_v1_in    = asr32(32'(s1_a_ff * {{16{t2[15]}}, t2}), 11);
      s2_dd_in    = asr32(32'(s1_d_ff * s1_d_ff), 12);
      s3_v2_in    = asr32(32'(s2_dd_ff * {{16{t3[15]}}, t3}), 14);
      s4_tfine_in = s3_v1_ff + s3_v2_ff;
      s4_t5_in    = s4_tfine_in + {s4_tfine_in[29:0], 2'b0} + 32'd128;
      s9_x2_in    = s8_sqp6_ff + {s8_x1p5_ff[46:0], 17'b0} + {{13{p4[15]}}, p4, 35'b0};
      s9_e_in     = asr64(s8_sqp3_ff, 8) + {s8_x1p2_ff[51:0], 12'b0}
                    + 64'h0000_8000_0000_0000;
      s10_pn_in   = 64'd1048576 - 64'(adc_p_dly_ff[8]);
      s10_n0_in   = {s10_pn_in[32:0], 31'b0} - s9_x2_ff;
      s12_n_in    = mul_sum(s11_n_ff);
      b1_p_in     = div_neg_ff[DivBits-1] ? 64'd0 - div_rq_ff[DivBits-1][63:0]
                                          : div_rq_ff[DivBits-1][63:0];
      b2_s_in     = asr64(b1_p_ff, 13);
      b6_t_in     = b5_p_ff + b5_y1_ff + b5_y2_ff;
      out_pres_in = b_dz_ff[BackStg-1] ? 32'd0
                    : b6_t_ff[39:8] + {{12{p7[15]}}, p7, 4'b0};
   end

   // restoring divider, one quotient bit per stage
   always_comb begin
      div_src[0]  = {64'b0, s13_ma_ff};
      div_msrc[0] = s13_mb_ff;
      for (int k = 1; k < DivBits; k++) begin
         div_src[k]  = div_rq_ff[k-1];
         div_msrc[k] = div_mb_ff[k-1];
      end
      for (int k = 0; k < DivBits; k++) begin
         div_rq_in[k] = {div_src[k][126:0], 1'b0};
         if (div_rq_in[k][127:64] >= div_msrc[k]) begin
            div_rq_in[k] = {div_rq_in[k][127:64] - div_msrc[k], div_rq_in[k][63:1], 1'b1};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumStg; i++) v_ff[i] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v_ff[0] <= req_valid;
         for (int i = 1; i < NumStg; i++) v_ff[i] <= v_ff[i-1];
         rsp_valid_ff <= v_ff[NumStg-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_a_ff <= s1_a_in;
         s1_d_ff <= s1_d_in;
         adc_p_dly_ff[0] <= req_raw_pressure;
         for (int i = 1; i < 9; i++) adc_p_dly_ff[i] <= adc_p_dly_ff[i-1];

         s2_v1_ff <= s2_v1_in;
         s2_dd_ff <= s2_dd_in;
         s3_v1_ff <= s2_v1_ff;
         s3_v2_ff <= s3_v2_in;
         s4_temp_ff <= asr32(s4_t5_in, 8);
         s4_x1_ff   <= {{32{s4_tfine_in[31]}}, s4_tfine_in} - 64'd128000;

         s5_sq_ff   <= sq_pp(s4_x1_ff);
         s5_x1p5_ff <= mul_pp(s4_x1_ff, {p5[15], p5});
         s5_x1p2_ff <= mul_pp(s4_x1_ff, {p2[15], p2});
         s6_sq_ff   <= sq_sum(s5_sq_ff);
         s6_x1p5_ff <= mul_sum(s5_x1p5_ff);
         s6_x1p2_ff <= mul_sum(s5_x1p2_ff);
         s7_sqp6_ff <= mul_pp(s6_sq_ff, {p6[15], p6});
         s7_sqp3_ff <= mul_pp(s6_sq_ff, {p3[15], p3});
         s7_x1p5_ff <= s6_x1p5_ff;
         s7_x1p2_ff <= s6_x1p2_ff;
         s8_sqp6_ff <= mul_sum(s7_sqp6_ff);
         s8_sqp3_ff <= mul_sum(s7_sqp3_ff);
         s8_x1p5_ff <= s7_x1p5_ff;
         s8_x1p2_ff <= s7_x1p2_ff;
         s9_x2_ff   <= s9_x2_in;
         s9_e_ff    <= s9_e_in;
         s10_ep1_ff <= mul_pp(s9_e_ff, {1'b0, p1});
         s10_n0_ff  <= s10_n0_in;
         s11_c_ff   <= asr64(mul_sum(s10_ep1_ff), 33);
         s11_n_ff   <= mul_pp(s10_n0_ff, 17'sd3125);
         s12_c_ff   <= s11_c_ff;
         s12_n_ff   <= s12_n_in;
         s13_ma_ff  <= s12_n_ff[63] ? 64'd0 - s12_n_ff : s12_n_ff;
         s13_mb_ff  <= s12_c_ff[63] ? 64'd0 - s12_c_ff : s12_c_ff;
         s13_neg_ff <= s12_n_ff[63] ^ s12_c_ff[63];
         s13_dz_ff  <= (s12_c_ff == 64'd0);

         for (int k = 0; k < DivBits; k++) begin
            div_rq_ff[k] <= div_rq_in[k];
            div_mb_ff[k] <= div_msrc[k];
         end
         div_neg_ff[0] <= s13_neg_ff;
         div_dz_ff[0]  <= s13_dz_ff;
         for (int k = 1; k < DivBits; k++) begin
            div_neg_ff[k] <= div_neg_ff[k-1];
            div_dz_ff[k]  <= div_dz_ff[k-1];
         end

         b1_p_ff    <= b1_p_in;
         b2_p_ff    <= b1_p_ff;
         b2_ss_ff   <= sq_pp(b2_s_in);
         b2_p8_ff   <= mul_pp(b1_p_ff, {p8[15], p8});
         b3_p_ff    <= b2_p_ff;
         b3_s2_ff   <= sq_sum(b2_ss_ff);
         b3_p8_ff   <= mul_sum(b2_p8_ff);
         b4_p_ff    <= b3_p_ff;
         b4_s2p9_ff <= mul_pp(b3_s2_ff, {p9[15], p9});
         b4_y2_ff   <= asr64(b3_p8_ff, 19);
         b5_p_ff    <= b4_p_ff;
         b5_y1_ff   <= asr64(mul_sum(b4_s2p9_ff), 25);
         b5_y2_ff   <= b4_y2_ff;
         b6_t_ff    <= b6_t_in;
         b_dz_ff[0] <= div_dz_ff[DivBits-1];
         for (int i = 1; i < BackStg; i++) b_dz_ff[i] <= b_dz_ff[i-1];

         temp_dly_ff[0] <= s4_temp_ff;
         for (int i = 1; i < TempDly; i++) temp_dly_ff[i] <= temp_dly_ff[i-1];

         out_temp_ff <= temp_dly_ff[TempDly-1];
         out_pres_ff <= out_pres_in;
         out_dz_ff   <= b_dz_ff[BackStg-1];
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_temperature_centi = out_temp_ff;
   assign rsp_pressure_q24_8    = out_pres_ff;
   assign rsp_divide_by_zero    = out_dz_ff;

   // a zero divisor always forces the pressure to zero
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_pressure_q24_8 == 32'd0)
      else $error("divide by zero flag with nonzero pressure");

   // the input side is held only by a waiting response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a blocked response");

   // the last stage reaches the output register when the pipeline moves
   a_last_stage: assert property (@(posedge clock) disable iff (reset)
      en && v_ff[NumStg-1] |=> rsp_valid)
      else $error("pipeline item lost before output");

   // divider remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      v_ff[FrontStg] && !div_dz_ff[0] |-> div_rq_ff[0][127:64] < div_mb_ff[0])
      else $error("divider remainder out of range");

endmodule
`default_nettype wire
